FILE: hdl/pfc_pkg.sv
// Shared types, constants and the PEC byte table function for the frame checker.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

    // PEC constants
    localparam logic [15:0] PEC_POLY    = 16'h4599;
    localparam logic [15:0] PEC_SEED    = 16'd16;
    localparam logic [15:0] PEC_TOP_BIT = 16'h4000;

    // Frame layout
    localparam int unsigned DATA_BYTES  = 6;
    localparam logic [2:0]  POS_PEC_HI  = 3'd6;
    localparam logic [2:0]  POS_PEC_LO  = 3'd7;

    // Register map: register index taken from the word address bit
    localparam int unsigned ADDR_W         = 3;
    localparam logic        REG_WORD_ORDER = 1'b0;

    // Word order codes
    localparam logic ORDER_LOW_FIRST  = 1'b0;
    localparam logic ORDER_HIGH_FIRST = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_byte;
    } t_pfc_in;

    typedef struct packed {
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] received_pec;
        logic        pec_ok;
    } t_pfc_out;

    // Remainder contributed by one 8-bit table index, MSB first
    function automatic logic [15:0] pec_entry(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'b0};
        for (int k = 0; k < 8; k++) begin
            if ((r & PEC_TOP_BIT) != 16'd0) begin
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // One byte step of the PEC remainder
    function automatic logic [15:0] pec_update(input logic [15:0] rem,
                                               input logic [7:0]  data);
        logic [7:0] idx;
        idx = rem[14:7] ^ data;
        return {rem[7:0], 8'h00} ^ pec_entry(idx);
    endfunction

    // Combine two bytes into a word as the order bit says
    function automatic logic [15:0] make_word(input logic       order,
                                              input logic [7:0] first,
                                              input logic [7:0] second);
        return (order == ORDER_HIGH_FIRST) ? {first, second} : {second, first};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pec15_response_frame_checker_core.sv
// Top level: PEC15 response frame checker with APB register port.
// A result is registered: it loads when the held last PEC byte advances.
// Throughput: one byte per cycle, unless a last byte waits on an untaken result;
// the byte-wise PEC update and result build sit between the input and result registers.
// Reset (synchronous, active low): empties both registers, remainder to seed 16,
// byte position to 0, word_order to 0; byte stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pec15_response_frame_checker_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire pfc_pkg::t_pfc_in        i_in,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output pfc_pkg::t_pfc_out            o_out,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [pfc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pfc_pkg::*;

    logic        r_word_order;
    logic        r_in_valid;
    t_pfc_in     r_in;
    logic [15:0] r_crc;
    logic [2:0]  r_byte_idx;
    logic [7:0]  r_data [DATA_BYTES];
    logic [7:0]  r_pec_hi;
    logic        r_out_valid;
    t_pfc_out    r_out;

    logic        cfg_wr;
    logic [2:0]  pos;
    logic [15:0] crc_in;
    logic        is_last;
    logic        advance;
    t_pfc_out    n_out;
    logic [15:0] rx_pec;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_WORD_ORDER) ? {31'd0, r_word_order} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_order <= ORDER_LOW_FIRST;
        end else if (cfg_wr && paddr[2] == REG_WORD_ORDER) begin
            r_word_order <= pwdata[0];
        end
    end

    // Frame position and remainder as seen by the held request
    assign pos     = r_in.first_byte ? 3'd0 : r_byte_idx;
    assign crc_in  = r_in.first_byte ? PEC_SEED : r_crc;
    assign is_last = (pos == POS_PEC_LO);

    // Advance unless a result would overwrite one not yet taken
    assign advance    = r_in_valid && (!is_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Update remainder and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= PEC_SEED;
            r_byte_idx <= 3'd0;
        end else if (advance) begin
            if (pos < POS_PEC_HI) begin
                r_crc      <= pec_update(crc_in, r_in.rx_byte);
                r_byte_idx <= pos + 3'd1;
            end else if (pos == POS_PEC_HI) begin
                r_crc      <= crc_in;
                r_byte_idx <= POS_PEC_LO;
            end else begin
                r_crc      <= PEC_SEED;
                r_byte_idx <= 3'd0;
            end
        end
    end

    // Store data bytes and the high PEC byte
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (pos < POS_PEC_HI) begin
                r_data[pos] <= r_in.rx_byte;
            end else if (pos == POS_PEC_HI) begin
                r_pec_hi <= r_in.rx_byte;
            end
        end
    end

    // Build the result
    assign rx_pec = {r_pec_hi, r_in.rx_byte};
    always_comb begin
        n_out.word_a       = make_word(r_word_order, r_data[0], r_data[1]);
        n_out.word_b       = make_word(r_word_order, r_data[2], r_data[3]);
        n_out.word_c       = make_word(r_word_order, r_data[4], r_data[5]);
        n_out.received_pec = rx_pec;
        n_out.pec_ok       = ({crc_in[14:0], 1'b0} == rx_pec);
    end

    // Result register: load on the last byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && is_last))
        else $error("result appeared without a last PEC byte");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_last) |=> (r_byte_idx == 3'd0 && r_crc == PEC_SEED))
        else $error("frame state not restarted after last byte");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && is_last))
        else $error("input stalled without a pending result");

    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule
`default_nettype wire

FILE: tb/pec15_response_frame_checker_core_test.sv
// Self-checking testbench for the PEC15 response frame checker: byte requests, PEC and word checks.
`timescale 1ns / 1ps
module pec15_response_frame_checker_core_test;

    import pfc_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_WORD_ORDER = {REG_WORD_ORDER, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_NO_REG     = 3'd4;
    localparam int unsigned       QUIET_LIMIT     = 4000;
    localparam int unsigned       DRAIN_CYCLES    = 4;

    typedef logic [5:0][7:0] t_frame_bytes;

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    t_pfc_in       i_in        = '0;
    logic          i_out_ready = 1'b0;
    logic          psel        = 1'b0;
    logic          penable     = 1'b0;
    logic          pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]   pwdata      = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    t_pfc_out      o_out;
    logic [31:0]   prdata;
    logic          pready;

    // Predictor state
    logic [14:0]   pec_rem     = PEC_SEED[14:0];
    logic [2:0]    frame_pos   = '0;
    t_frame_bytes  frame_data  = '0;
    logic [7:0]    pec_hi      = '0;
    logic          word_order_q = ORDER_LOW_FIRST;
    t_pfc_out      expected_frames [$];

    int unsigned   errors      = 0;
    int unsigned   n_bytes     = 0;
    int unsigned   n_frames    = 0;
    int unsigned   n_pec_good  = 0;
    int unsigned   n_pec_bad   = 0;
    int unsigned   stall_pct   = 0;
    int unsigned   quiet_cycles = 0;

    pec15_response_frame_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shift one byte through the 15-bit PEC register, MSB first
    function automatic logic [14:0] pec_shift_byte(input logic [14:0] rem,
                                                   input logic [7:0]  b);
        logic feedback;
        int   i;
        for (i = 7; i >= 0; i--) begin
            feedback = b[i] ^ rem[14];
            rem = {rem[13:0], 1'b0};
            if (feedback) begin
                rem = rem ^ PEC_POLY[14:0];
            end
        end
        return rem;
    endfunction

    // Transmitted PEC of six data bytes: final remainder shifted up one bit
    function automatic logic [15:0] frame_pec(input t_frame_bytes d);
        logic [14:0] rem;
        rem = PEC_SEED[14:0];
        for (int i = 0; i < DATA_BYTES; i++) begin
            rem = pec_shift_byte(rem, d[i]);
        end
        return {rem, 1'b0};
    endfunction

    function automatic logic [15:0] combine_bytes(input logic order,
                                                  input logic [7:0] b0,
                                                  input logic [7:0] b1);
        if (order == ORDER_HIGH_FIRST) begin
            return {b0, b1};
        end
        return {b1, b0};
    endfunction

    // Advance the predicted frame state by one accepted request
    function automatic void absorb_byte(input t_pfc_in item);
        t_pfc_out res;
        n_bytes++;
        if (item.first_byte) begin
            frame_pos = '0;
            pec_rem   = PEC_SEED[14:0];
        end
        if (frame_pos < POS_PEC_HI) begin
            frame_data[frame_pos] = item.rx_byte;
            pec_rem   = pec_shift_byte(pec_rem, item.rx_byte);
            frame_pos = frame_pos + 3'd1;
        end else if (frame_pos == POS_PEC_HI) begin
            pec_hi    = item.rx_byte;
            frame_pos = POS_PEC_LO;
        end else begin
            res.word_a       = combine_bytes(word_order_q, frame_data[0], frame_data[1]);
            res.word_b       = combine_bytes(word_order_q, frame_data[2], frame_data[3]);
            res.word_c       = combine_bytes(word_order_q, frame_data[4], frame_data[5]);
            res.received_pec = {pec_hi, item.rx_byte};
            res.pec_ok       = ({pec_rem, 1'b0} == res.received_pec);
            expected_frames.push_back(res);
            frame_pos = '0;
            pec_rem   = PEC_SEED[14:0];
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Hold one request until it is accepted, leave valid high
    task automatic send_byte(input logic [7:0] b, input logic first);
        @(negedge i_clk);
        i_in_valid         = 1'b1;
        i_in.rx_byte       = b;
        i_in.first_byte    = first;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(i_in);
    endtask

    // Drop valid for a random number of cycles
    task automatic idle_gap(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic send_frame(input t_frame_bytes d, input logic [15:0] pec,
                              input logic first, input int unsigned pct);
        for (int i = 0; i < DATA_BYTES; i++) begin
            idle_gap(pct);
            send_byte(d[i], (i == 0) ? first : 1'b0);
        end
        idle_gap(pct);
        send_byte(pec[15:8], 1'b0);
        idle_gap(pct);
        send_byte(pec[7:0], 1'b0);
    endtask

    // Stop sending and wait for every pending result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr[ADDR_W-1] == REG_WORD_ORDER) begin
            word_order_q = data[0];
        end
    endtask

    task automatic set_word_order(input logic order);
        logic [31:0] v;
        v    = $urandom;
        v[0] = order;
        write_reg(ADDR_WORD_ORDER, v);
    endtask

    // Mostly well-formed frames, some cut short, some noise
    task automatic run_random_phase(input int unsigned n_items, input int unsigned pct);
        int unsigned  start;
        bit           paused;
        t_frame_bytes d;
        logic [15:0]  pec;
        int unsigned  kind;
        int unsigned  len;
        start  = n_bytes;
        paused = 1'b0;
        while (n_bytes - start < n_items) begin
            kind = $urandom_range(99);
            for (int i = 0; i < DATA_BYTES; i++) begin
                d[i] = pick_byte();
            end
            if (kind < 70) begin
                pec = frame_pec(d);
                if ($urandom_range(99) < 40) begin
                    case ($urandom_range(2))
                        0: pec = pec ^ (16'h0001 << $urandom_range(15));
                        1: pec = 16'($urandom);
                        default: pec = ~pec;
                    endcase
                end
                send_frame(d, pec, (frame_pos != 0) || ($urandom_range(4) != 0), pct);
            end else if (kind < 85) begin
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++) begin
                    idle_gap(pct);
                    send_byte(pick_byte(), i == 0);
                end
            end else begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    idle_gap(pct);
                    send_byte(pick_byte(), $urandom_range(3) == 0);
                end
            end
            // hold off once mid-phase until the pipeline is empty
            if (!paused && (n_bytes - start >= n_items / 2)) begin
                settle();
                paused = 1'b1;
            end
        end
        // close on a frame boundary so the next register write sees no partial frame
        for (int i = 0; i < DATA_BYTES; i++) begin
            d[i] = pick_byte();
        end
        send_frame(d, frame_pec(d), 1'b1, pct);
        settle();
    endtask

    // Extremes, restart mid-frame, bad PEC, continuation without a first flag
    task automatic test_directed();
        t_frame_bytes d;
        stall_pct = 0;
        d = '0;
        send_frame(d, frame_pec(d), 1'b1, 0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        d = {6{8'hFF}};
        send_frame(d, frame_pec(d), 1'b1, 0);
        settle();
        set_word_order(ORDER_HIGH_FIRST);
        // a write outside the register map must leave the order alone
        write_reg(ADDR_NO_REG, 32'h0000_0000);
        d = {8'h5A, 8'hC3, 8'h01, 8'h80, 8'hFE, 8'h7F};
        send_frame(d, frame_pec(d) ^ 16'h8000, 1'b0, 0);
        settle();
    endtask

    task automatic test_streaming();
        stall_pct = 0;
        set_word_order(ORDER_LOW_FIRST);
        run_random_phase(170, 0);
    endtask

    task automatic test_sender_gaps();
        stall_pct = 0;
        set_word_order(ORDER_HIGH_FIRST);
        run_random_phase(170, 75);
    endtask

    task automatic test_receiver_stalls();
        stall_pct = 75;
        set_word_order(ORDER_LOW_FIRST);
        run_random_phase(170, 0);
    endtask

    task automatic test_both_idle();
        stall_pct = 11;
        set_word_order(ORDER_HIGH_FIRST);
        run_random_phase(170, 11);
    endtask

    // Randomize result ready
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_pfc_out exp_frame;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out);
            end else begin
                exp_frame = expected_frames.pop_front();
                n_frames++;
                if (exp_frame.pec_ok) n_pec_good++;
                else n_pec_bad++;
                check_field("word_a", exp_frame.word_a, o_out.word_a);
                check_field("word_b", exp_frame.word_b, o_out.word_b);
                check_field("word_c", exp_frame.word_c, o_out.word_c);
                check_field("received_pec", exp_frame.received_pec, o_out.received_pec);
                check_field("pec_ok", {15'd0, exp_frame.pec_ok}, {15'd0, o_out.pec_ok});
            end
        end
    end

    // End the run if no request moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     expected_frames.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        settle();
        repeat (8) @(posedge i_clk);
        if (expected_frames.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_frames.size());
        end
        $display("Sent %0d bytes under both word orders and four idle patterns;",
                 n_bytes);
        $display("checked %0d frames, %0d with matching PEC and %0d with bad PEC.",
                 n_frames, n_pec_good, n_pec_bad);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
